### sv/tsdod_pkg.sv
// Shared types and constants for the delta-of-delta timestamp encoder.
`timescale 1ns / 1ps
package tsdod_pkg;

  typedef struct packed {
    logic               action;
    logic signed [63:0] timestamp;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_t;

  typedef struct packed {
    logic [71:0] data;
    logic [3:0]  count;
  } burst_t;

  localparam logic ACT_APPEND = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  localparam logic [1:0] PFX_7  = 2'h2;
  localparam logic [2:0] PFX_9  = 3'h6;
  localparam logic [3:0] PFX_12 = 4'hE;
  localparam logic [3:0] PFX_32 = 4'hF;

  localparam logic signed [63:0] LO_7  = -64'sd63;
  localparam logic signed [63:0] HI_7  = 64'sd64;
  localparam logic signed [63:0] LO_9  = -64'sd255;
  localparam logic signed [63:0] HI_9  = 64'sd256;
  localparam logic signed [63:0] LO_12 = -64'sd2047;
  localparam logic signed [63:0] HI_12 = 64'sd2048;

  localparam logic [6:0] LEN_ZERO = 7'd1;
  localparam logic [6:0] LEN_7    = 7'd9;
  localparam logic [6:0] LEN_9    = 7'd12;
  localparam logic [6:0] LEN_12   = 7'd16;
  localparam logic [6:0] LEN_32   = 7'd36;
  localparam logic [6:0] LEN_FULL = 7'd64;

endpackage

### sv/tsdod_code.sv
// Delta-of-delta classifier producing a left-aligned code word and its length.
`timescale 1ns / 1ps
module tsdod_code (
  input  logic               first,
  input  logic signed [63:0] timestamp,
  input  logic        [63:0] pred,
  output logic        [63:0] code,
  output logic        [6:0]  len
);

  logic        [63:0] dod;
  logic signed [63:0] sdod;

  assign dod  = timestamp - pred;
  assign sdod = $signed(dod);

  always_comb begin
    if (first) begin
      code = timestamp;
      len  = tsdod_pkg::LEN_FULL;
    end else if (dod == 64'd0) begin
      code = 64'd0;
      len  = tsdod_pkg::LEN_ZERO;
    end else if (sdod >= tsdod_pkg::LO_7 && sdod <= tsdod_pkg::HI_7) begin
      code = {tsdod_pkg::PFX_7, ~dod[6], dod[5:0], 55'd0};
      len  = tsdod_pkg::LEN_7;
    end else if (sdod >= tsdod_pkg::LO_9 && sdod <= tsdod_pkg::HI_9) begin
      code = {tsdod_pkg::PFX_9, ~dod[8], dod[7:0], 52'd0};
      len  = tsdod_pkg::LEN_9;
    end else if (sdod >= tsdod_pkg::LO_12 && sdod <= tsdod_pkg::HI_12) begin
      code = {tsdod_pkg::PFX_12, ~dod[11], dod[10:0], 48'd0};
      len  = tsdod_pkg::LEN_12;
    end else begin
      code = {tsdod_pkg::PFX_32, dod[31:0], 28'd0};
      len  = tsdod_pkg::LEN_32;
    end
  end

endmodule

### sv/tsdod_emit.sv
// Byte burst register that drains packed bytes one per cycle while not stalled, MSB first.
`timescale 1ns / 1ps
module tsdod_emit (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  tsdod_pkg::burst_t burst,
  output logic              free,
  output logic              dst_valid,
  input  logic              dst_stall,
  output tsdod_pkg::out_t   dst_item
);

  logic [71:0] data;
  logic [3:0]  count;

  assign dst_valid            = (count != 4'd0);
  assign dst_item.out_byte    = data[71:64];
  assign dst_item.last_of_run = (count == 4'd1);
  assign free                 = (count == 4'd0) || (count == 4'd1 && !dst_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 4'd0;
    end else if (load) begin
      count <= burst.count;
    end else if (dst_valid && !dst_stall) begin
      count <= count - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= burst.data;
    end else if (dst_valid && !dst_stall) begin
      data <= {data[63:0], 8'd0};
    end
  end

endmodule

### sv/timestamp_delta_of_delta_encoder.sv
// Delta-of-delta timestamp encoder top level: input register, series state, bit packer.
// An item is registered in the input register on accept and coded combinationally there; its
// bytes load into the burst register once that is free, and then go to the output.
// Each item loads the N bytes that it completes into the burst register: N is up
// to 5 for a later timestamp, up to 8 for the first one, and 0 or 1 for a finish.
// The byte-wide burst register drains one byte per cycle while the output is not
// stalled; the input register takes the next item while the burst drains, and an
// item that completes no byte leaves the burst register free.
`timescale 1ns / 1ps
module timestamp_delta_of_delta_encoder (
  input  logic             clk,
  input  logic             rst,
  input  logic             src_valid,
  output logic             src_stall,
  input  tsdod_pkg::in_t   src_item,
  output logic             dst_valid,
  input  logic             dst_stall,
  output tsdod_pkg::out_t  dst_item
);

  logic           in_full;
  tsdod_pkg::in_t in_item;

  logic        started;
  logic [63:0] prev_time;
  logic [63:0] pred;
  logic [6:0]  pending_bits;
  logic [2:0]  pending_count;

  logic              free;
  logic              fire;
  logic              finish;
  logic [63:0]       code;
  logic [6:0]        len;
  logic [7:0]        head;
  logic [71:0]       combined;
  logic [71:0]       shifted;
  logic [6:0]        total;
  logic [2:0]        count_next;
  logic [6:0]        bits_next;
  tsdod_pkg::burst_t burst;

  assign src_stall = in_full && !free;
  assign fire      = in_full && free;
  assign finish    = (in_item.action == tsdod_pkg::ACT_FINISH);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (src_valid && !src_stall) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (src_valid && !src_stall) begin
      in_item <= src_item;
    end
  end

  tsdod_code u_code (
    .first     (!started),
    .timestamp (in_item.timestamp),
    .pred      (pred),
    .code      (code),
    .len       (len)
  );

  always_comb begin
    head       = 8'({1'b0, pending_bits} << (4'd8 - {1'b0, pending_count}));
    combined   = {head, 64'd0} | ({code, 8'd0} >> pending_count);
    total      = {4'd0, pending_count} + len;
    shifted    = combined << {total[6:3], 3'd0};
    count_next = total[2:0];
    bits_next  = 7'(shifted[71:64] >> (4'd8 - {1'b0, count_next}));
    if (finish) begin
      burst.data  = {head, 64'd0};
      burst.count = {3'd0, (pending_count != 3'd0)};
    end else begin
      burst.data  = combined;
      burst.count = total[6:3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started       <= 1'b0;
      prev_time     <= 64'd0;
      pred          <= 64'd0;
      pending_bits  <= 7'd0;
      pending_count <= 3'd0;
    end else if (fire) begin
      if (finish) begin
        started       <= 1'b0;
        prev_time     <= 64'd0;
        pred          <= 64'd0;
        pending_bits  <= 7'd0;
        pending_count <= 3'd0;
      end else begin
        started       <= 1'b1;
        prev_time     <= in_item.timestamp;
        pred          <= started ? ({in_item.timestamp[62:0], 1'b0} - prev_time)
                                 : in_item.timestamp;
        pending_bits  <= bits_next;
        pending_count <= count_next;
      end
    end
  end

  tsdod_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .burst     (burst),
    .free      (free),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_item  (dst_item)
  );

endmodule

### sv/tsdod_check.sv
// Port-level checker for the delta-of-delta timestamp encoder, bound to the top level.
`timescale 1ns / 1ps
module tsdod_check (
  input logic            clk,
  input logic            rst,
  input logic            src_stall,
  input logic            dst_valid,
  input logic            dst_stall,
  input tsdod_pkg::out_t dst_item
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_stall |=> dst_valid && $stable(dst_item))
    else $error("output item changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !dst_valid)
    else $error("output valid right after reset");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    dst_valid && !dst_stall && !dst_item.last_of_run |=> dst_valid)
    else $error("byte run broken before its last byte");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    src_stall |-> dst_valid)
    else $error("input stalled with no output pending");

endmodule

bind timestamp_delta_of_delta_encoder tsdod_check u_tsdod_check (
  .clk       (clk),
  .rst       (rst),
  .src_stall (src_stall),
  .dst_valid (dst_valid),
  .dst_stall (dst_stall),
  .dst_item  (dst_item)
);

### tb/sv/tb_timestamp_delta_of_delta_encoder.sv
// Testbench for the delta-of-delta timestamp encoder: randomized items, byte scoreboard.
`timescale 1ns / 1ps
module tb_timestamp_delta_of_delta_encoder;

  localparam int IDLE_LIMIT = 3000;
  localparam int LONG_HOLD  = 150;

  class byte_stream_board;
    tsdod_pkg::out_t expected_bytes[$];
    tsdod_pkg::out_t run_bytes[$];
    int              errors;
    logic            started;
    logic [63:0]     last_stamp;
    logic [63:0]     last_delta;
    logic [7:0]      part;
    int              part_len;

    function new();
      errors = 0;
      clear_series();
    endfunction

    function void clear_series();
      started    = 1'b0;
      last_stamp = '0;
      last_delta = '0;
      part       = '0;
      part_len   = 0;
    endfunction

    function void push_byte(logic [7:0] b);
      tsdod_pkg::out_t r;
      r.out_byte    = b;
      r.last_of_run = 1'b0;
      run_bytes.push_back(r);
    endfunction

    function void shift_in(logic [63:0] v, int n);
      for (int i = n - 1; i >= 0; i--) begin
        part = {part[6:0], v[i]};
        part_len++;
        if (part_len == 8) begin
          push_byte(part);
          part     = '0;
          part_len = 0;
        end
      end
    endfunction

    function void note_item(tsdod_pkg::in_t it);
      logic [63:0]        delta;
      logic signed [63:0] dod;
      run_bytes = {};
      if (it.action == tsdod_pkg::ACT_FINISH) begin
        if (part_len > 0) push_byte(part << (8 - part_len));
        clear_series();
      end else if (!started) begin
        shift_in(it.timestamp, 64);
        last_stamp = it.timestamp;
        last_delta = '0;
        started    = 1'b1;
      end else begin
        delta = it.timestamp - last_stamp;
        dod   = delta - last_delta;
        if (dod == 0) begin
          shift_in(64'd0, 1);
        end else if (dod >= tsdod_pkg::LO_7 && dod <= tsdod_pkg::HI_7) begin
          shift_in(64'(tsdod_pkg::PFX_7), 2);
          shift_in(dod + 64'd64, 7);
        end else if (dod >= tsdod_pkg::LO_9 && dod <= tsdod_pkg::HI_9) begin
          shift_in(64'(tsdod_pkg::PFX_9), 3);
          shift_in(dod + 64'd256, 9);
        end else if (dod >= tsdod_pkg::LO_12 && dod <= tsdod_pkg::HI_12) begin
          shift_in(64'(tsdod_pkg::PFX_12), 4);
          shift_in(dod + 64'd2048, 12);
        end else begin
          shift_in(64'(tsdod_pkg::PFX_32), 4);
          shift_in(dod, 32);
        end
        last_delta = delta;
        last_stamp = it.timestamp;
      end
      if (run_bytes.size() > 0) run_bytes[$].last_of_run = 1'b1;
      foreach (run_bytes[i]) expected_bytes.push_back(run_bytes[i]);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_byte(tsdod_pkg::out_t got);
      tsdod_pkg::out_t want;
      if (expected_bytes.size() == 0) begin
        report($sformatf("unexpected byte %h", got.out_byte));
      end else begin
        want = expected_bytes.pop_front();
        if (got.out_byte !== want.out_byte)
          report($sformatf("out_byte got %h want %h", got.out_byte, want.out_byte));
        if (got.last_of_run !== want.last_of_run)
          report($sformatf("last_of_run got %b want %b", got.last_of_run, want.last_of_run));
      end
    endtask

    task check_leftover();
      if (expected_bytes.size() != 0)
        report($sformatf("%0d bytes never arrived", expected_bytes.size()));
    endtask
  endclass

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            src_valid = 1'b0;
  logic            src_stall;
  tsdod_pkg::in_t  src_item = '0;
  logic            dst_valid;
  logic            dst_stall = 1'b0;
  tsdod_pkg::out_t dst_item;

  byte_stream_board board = new();

  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          hold_request = 0;
  int          idle_cycles = 0;
  logic        gen_started = 1'b0;
  logic [63:0] gen_stamp = '0;
  logic [63:0] gen_delta = '0;

  timestamp_delta_of_delta_encoder uut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_item  (src_item),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_item  (dst_item)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && dst_valid && !dst_stall) board.check_byte(dst_item);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        dst_stall <= 1'b1;
        hold_left--;
      end else begin
        dst_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((src_valid && !src_stall) || (dst_valid && !dst_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb_timestamp_delta_of_delta_encoder: errors");
    $finish;
  end

  task offer(tsdod_pkg::in_t it);
    src_valid <= 1'b1;
    src_item  <= it;
    do @(posedge clk); while (src_stall);
    board.note_item(it);
    if ($urandom_range(99) < tx_idle_pct) begin
      src_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  task send_stamp(logic [63:0] t);
    tsdod_pkg::in_t it;
    it.action    = tsdod_pkg::ACT_APPEND;
    it.timestamp = t;
    offer(it);
    gen_delta   = gen_started ? t - gen_stamp : 64'd0;
    gen_stamp   = t;
    gen_started = 1'b1;
  endtask

  task send_finish();
    tsdod_pkg::in_t it;
    it.action    = tsdod_pkg::ACT_FINISH;
    it.timestamp = {$urandom, $urandom};
    offer(it);
    gen_started = 1'b0;
  endtask

  task send_dod(logic signed [63:0] dod);
    if (!gen_started) send_stamp({$urandom, $urandom});
    else send_stamp(gen_stamp + gen_delta + dod);
  endtask

  task run_random(int n);
    int                 pick;
    int                 offset;
    logic signed [63:0] dod;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_finish();
      end else if (pick < 16) begin
        send_stamp({$urandom, $urandom});
      end else begin
        case ($urandom_range(9))
          0, 1, 2: offset = 0;
          3, 4, 5: offset = $urandom_range(127) - 63;
          6:       offset = $urandom_range(511) - 255;
          7:       offset = $urandom_range(4095) - 2047;
          default: offset = 1;
        endcase
        dod = offset;
        if (pick >= 90) dod = {$urandom, $urandom};
        else if (pick >= 86) dod = $signed({31'd0, $urandom, 1'b1}) * ($urandom_range(1) ? 1 : -1);
        send_dod(dod);
      end
    end
  endtask

  task wait_for_bytes();
    while (board.expected_bytes.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct = 12;
    rx_idle_pct = 63;
    send_finish();
    send_finish();
    send_stamp(64'h7FFF_FFFF_FFFF_FFFF);
    send_stamp(64'h8000_0000_0000_0000);
    send_stamp(64'h7FFF_FFFF_FFFF_FFFF);
    send_finish();
    send_stamp(64'd0);
    send_dod(0);
    send_dod(64);
    send_dod(-63);
    send_dod(65);
    send_dod(-64);
    send_dod(256);
    send_dod(-255);
    send_dod(257);
    send_dod(-256);
    send_dod(2048);
    send_dod(-2047);
    send_dod(2049);
    send_dod(-2048);
    send_dod(64'sh0000_0001_2345_6789);
    send_dod(64'sh8000_0000_0000_0000);
    send_finish();
    run_random(30);
    src_valid <= 1'b0;
    wait_for_bytes();

    tx_idle_pct = 63;
    rx_idle_pct = 12;
    run_random(30);
    src_valid <= 1'b0;
    wait_for_bytes();

    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    hold_request = LONG_HOLD;
    run_random(45);
    send_finish();
    src_valid <= 1'b0;
    wait_for_bytes();
    repeat (16) @(posedge clk);
    board.check_leftover();

    if (board.errors == 0) begin
      $display("tb_timestamp_delta_of_delta_encoder: clean");
    end else begin
      $display("tb_timestamp_delta_of_delta_encoder: errors");
    end
    $finish;
  end

endmodule
